### sv/stng_pkg.sv
// Shared types, constants and the volume table for the tone/noise sound generator.
`timescale 1ns / 1ps
package stng_pkg;

  localparam logic [1:0] CFG_CLOCKS_PER_SAMPLE = 2'd0;
  localparam logic [1:0] CFG_OVERSAMPLE_ENABLE = 2'd1;
  localparam logic [1:0] CFG_MUTE_MASK         = 2'd2;

  localparam logic [1:0] CMD_CHIP_WRITE   = 2'd0;
  localparam logic [1:0] CMD_STEREO_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK         = 2'd2;

  localparam logic [19:0] CLOCKS_RESET  = 20'd332470;
  localparam logic [3:0]  MUTE_RESET    = 4'hF;
  localparam logic [16:0] WHITE_TAPS    = 17'h12000;
  localparam logic [16:0] PERIODIC_TAP  = 17'h08000;
  localparam logic [9:0]  NOISE_FOLLOW  = 10'd128;
  localparam logic [3:0]  DIV_STEPS     = 4'd13;
  localparam logic signed [10:0] UNIT_WEIGHT = 11'sd256;
  localparam logic signed [1:0]  POL_POS = 2'sb01;
  localparam logic signed [1:0]  POL_NEG = 2'sb11;
  localparam logic [2:0]  LATCH_NONE    = 3'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MUL,
    OP_ACC,
    OP_DEC,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_LOAD_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] ch;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } out_item_t;

  function automatic logic [12:0] vol_level(input logic [3:0] att);
    logic [12:0] lvl;
    unique case (att)
      4'd0, 4'd1, 4'd2: lvl = 13'd8028;
      4'd3:  lvl = 13'd6842;
      4'd4:  lvl = 13'd5603;
      4'd5:  lvl = 13'd4471;
      4'd6:  lvl = 13'd3636;
      4'd7:  lvl = 13'd2909;
      4'd8:  lvl = 13'd2316;
      4'd9:  lvl = 13'd1778;
      4'd10: lvl = 13'd1427;
      4'd11: lvl = 13'd1104;
      4'd12: lvl = 13'd862;
      4'd13: lvl = 13'd673;
      4'd14: lvl = 13'd539;
      default: lvl = 13'd0;
    endcase
    return lvl;
  endfunction

endpackage

### sv/stng_ctrl.sv
// Sequencer for the sound generator: steps mix, counter update and edge-weight divide.
`timescale 1ns / 1ps
module stng_ctrl
  import stng_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DEC  = 3'd3;
  localparam logic [2:0] ST_EVAL = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_UPD  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] ch_q, ch_d;
  logic [3:0] step_q, step_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    step_d    = step_q;
    cmd_o.op  = OP_NONE;
    cmd_o.ch  = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (in_cmd_i == CMD_TICK) begin
            state_d = ST_MUL;
            ch_d    = 2'd0;
          end
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        if (ch_q == 2'd3) begin
          ch_d    = 2'd0;
          state_d = ST_DEC;
        end else begin
          ch_d    = 2'(ch_q + 2'd1);
          state_d = ST_MUL;
        end
      end
      ST_DEC: begin
        cmd_o.op = OP_DEC;
        state_d  = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.op = OP_DIV_INIT;
        step_d   = 4'd0;
        state_d  = status_i.need_div ? ST_DIV : ST_UPD;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        step_d   = 4'(step_q + 4'd1);
        if (step_q == 4'(DIV_STEPS - 4'd1)) state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.op = OP_UPDATE;
        if (ch_q == 2'd3) begin
          state_d = ST_OUT;
        end else begin
          ch_d    = 2'(ch_q + 2'd1);
          state_d = ST_DEC;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_LOAD_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= 2'd0;
      step_q  <= 4'd0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      step_q  <= step_d;
    end
  end

endmodule

### sv/stng_dp.sv
// Datapath for the sound generator: chip state, mixer, counters, divider and output register.
`timescale 1ns / 1ps
module stng_dp
  import stng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  in_item_t    in_item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  logic [19:0] cps_q, cps_d;
  logic        over_q, over_d;
  logic [3:0]  mute_q, mute_d;

  logic [3:0]         vol_q[4], vol_d[4];
  logic [9:0]         period_q[4], period_d[4];
  logic signed [11:0] cnt_q[4], cnt_d[4];
  logic signed [1:0]  pol_q[4], pol_d[4];
  logic signed [9:0]  ew_q[3], ew_d[3];
  logic [16:0] nsr_q, nsr_d;
  logic        white_q, white_d;
  logic [2:0]  lat_ch_q, lat_ch_d;
  logic [3:0]  lat_lo_q, lat_lo_d;
  logic [7:0]  stereo_q, stereo_d;
  logic [15:0] frac_q, frac_d;
  logic [4:0]  n_q, n_d;
  logic signed [11:0] dec2_q, dec2_d;
  logic signed [15:0] left_q, left_d, right_q, right_d;
  logic signed [24:0] prod_q, prod_d;
  logic [12:0] quo_q, quo_d;
  logic [4:0]  rem_q, rem_d;
  logic        dneg_q, dneg_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic [1:0]         k;
  logic [7:0]         d;
  logic [12:0]        lvl;
  logic signed [13:0] base;
  logic signed [9:0]  ew_cur;
  logic signed [10:0] weight;
  logic signed [24:0] biased;
  logic signed [15:0] part;
  logic [20:0]        frac_sum;
  logic [9:0]         wr_period;
  logic signed [11:0] cur_v, dec_v, new_v;
  logic [9:0]         cur_p;
  logic signed [12:0] r1, r2, r3, r4;
  logic signed [11:0] reloaded;
  logic signed [6:0]  snum;
  logic [4:0]         smag;
  logic [5:0]         shifted;
  logic [6:0]         trial;
  logic signed [9:0]  quot;
  logic signed [1:0]  flip;
  logic [16:0]        nsr_seed;
  logic               need_div;

  assign k = cmd_i.ch;
  assign d = in_item_i.data;

  always_comb begin
    unique case (k)
      2'd0: ew_cur = ew_q[0];
      2'd1: ew_cur = ew_q[1];
      2'd2: ew_cur = ew_q[2];
      default: ew_cur = '0;
    endcase
  end

  assign lvl    = vol_level(vol_q[k]);
  assign cur_v  = cnt_q[k];
  assign cur_p  = period_q[k];
  assign need_div = cur_v[11] && (k != 2'd3) && over_q && (n_q != 5'd0);

  // reload: at most four period adds; the first non-negative sum is taken, else the fourth
  assign r1 = {cur_v[11], cur_v} + signed'({3'b0, cur_p});
  assign r2 = r1 + signed'({3'b0, cur_p});
  assign r3 = r2 + signed'({3'b0, cur_p});
  assign r4 = r3 + signed'({3'b0, cur_p});
  assign reloaded = !r1[12] ? r1[11:0] : !r2[12] ? r2[11:0] :
                    !r3[12] ? r3[11:0] : r4[11:0];

  assign biased = prod_q + signed'({17'b0, {8{prod_q[24]}}});
  assign part   = biased[23:8];

  assign snum    = signed'({2'b0, n_q}) + signed'({cur_v[5:0], 1'b0});
  assign smag    = snum[6] ? 5'(-snum) : snum[4:0];
  assign shifted = {rem_q, quo_q[12]};
  assign trial   = {1'b0, shifted} - {2'b0, n_q};
  assign quot    = dneg_q ? 10'(-signed'({1'b0, quo_q[8:0]})) : signed'({1'b0, quo_q[8:0]});
  assign flip    = 2'(-pol_q[k]);
  assign nsr_seed = (nsr_q == 17'd0) ? 17'd1 : nsr_q;

  assign status_o.need_div = need_div;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cps_d = cps_q; over_d = over_q; mute_d = mute_q;
    vol_d = vol_q; period_d = period_q; cnt_d = cnt_q; pol_d = pol_q; ew_d = ew_q;
    nsr_d = nsr_q; white_d = white_q; lat_ch_d = lat_ch_q; lat_lo_d = lat_lo_q;
    stereo_d = stereo_q; frac_d = frac_q; n_d = n_q; dec2_d = dec2_q;
    left_d = left_q; right_d = right_q; prod_d = prod_q;
    quo_d = quo_q; rem_d = rem_q; dneg_d = dneg_q;
    out_valid_d = out_valid_q; out_d = out_q;
    base = '0; weight = UNIT_WEIGHT; frac_sum = '0; wr_period = '0;
    dec_v = '0; new_v = '0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CLOCKS_PER_SAMPLE: cps_d = cfg_data_i;
        CFG_OVERSAMPLE_ENABLE: over_d = cfg_data_i[0];
        CFG_MUTE_MASK:         mute_d = cfg_data_i[3:0];
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    unique case (cmd_i.op)
      OP_ACCEPT: begin
        unique case (in_item_i.cmd)
          CMD_CHIP_WRITE: begin
            if (!d[7]) begin
              if (lat_ch_q != LATCH_NONE) begin
                wr_period = {d[5:0], lat_lo_q};
                if (wr_period < 10'd4) wr_period = 10'd0;
                period_d[lat_ch_q[1:0]] = wr_period;
                if (pol_q[lat_ch_q[1:0]] == 2'sd0) pol_d[lat_ch_q[1:0]] = POL_POS;
              end
            end else if (!d[4]) begin
              if (d[6:5] == 2'b11) begin
                period_d[3] = 10'(10'h10 << d[1:0]);
                white_d     = d[2];
                nsr_d       = '0;
                lat_ch_d    = LATCH_NONE;
              end else begin
                lat_ch_d = {1'b0, d[6:5]};
                lat_lo_d = d[3:0];
              end
            end else begin
              vol_d[d[6:5]] = d[3:0];
              lat_ch_d      = LATCH_NONE;
            end
          end
          CMD_STEREO_WRITE: stereo_d = d;
          CMD_TICK: begin
            left_d   = '0;
            right_d  = '0;
            frac_sum = {5'b0, frac_q} + {1'b0, cps_q};
            n_d      = frac_sum[20:16];
            frac_d   = frac_sum[15:0];
          end
          default: ;
        endcase
      end
      OP_MUL: begin
        if (k == 2'd3) begin
          base = (mute_q[3] && nsr_q[0]) ? signed'({1'b0, lvl}) : 14'sd0;
        end else if (mute_q[k] && pol_q[k] == POL_POS) begin
          base = signed'({1'b0, lvl});
        end else if (mute_q[k] && pol_q[k] == POL_NEG) begin
          base = 14'(-signed'({1'b0, lvl}));
        end
        if (over_q && k != 2'd3 && ew_cur != 10'sd0) weight = {ew_cur[9], ew_cur};
        prod_d = base * weight;
      end
      OP_ACC: begin
        if (stereo_q[{1'b1, k}]) left_d  = 16'(left_q + part);
        if (stereo_q[{1'b0, k}]) right_d = 16'(right_q + part);
      end
      OP_DEC: begin
        dec_v = 12'(cur_v - signed'({7'b0, n_q}));
        if (k == 2'd3 && cur_p == NOISE_FOLLOW) new_v = dec2_q;
        else if (cur_p != 10'd0) new_v = dec_v;
        else new_v = cur_v;
        cnt_d[k] = new_v;
        if (k == 2'd2) dec2_d = new_v;
      end
      OP_DIV_INIT: begin
        dneg_d = snum[6];
        quo_d  = {smag, 8'b0};
        rem_d  = '0;
      end
      OP_DIV_STEP: begin
        if (!trial[6]) rem_d = trial[4:0];
        else rem_d = shifted[4:0];
        quo_d = {quo_q[11:0], !trial[6]};
      end
      OP_UPDATE: begin
        if (cur_v[11]) begin
          for (int i = 0; i < 3; i++) begin
            if (k == 2'(i) && need_div) ew_d[i] = quot;
          end
          pol_d[k] = flip;
          if (cur_p != 10'd0) cnt_d[k] = reloaded;
          if (k == 2'd3 && flip == POL_POS) begin
            if (nsr_seed[0]) nsr_d = (nsr_seed >> 1) ^ (white_q ? WHITE_TAPS : PERIODIC_TAP);
            else nsr_d = nsr_seed >> 1;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (k == 2'(i)) ew_d[i] = '0;
          end
        end
      end
      OP_LOAD_OUT: begin
        out_d.left_sample  = left_q;
        out_d.right_sample = right_q;
        out_valid_d        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q       <= CLOCKS_RESET;
      over_q      <= 1'b0;
      mute_q      <= MUTE_RESET;
      for (int i = 0; i < 4; i++) begin
        vol_q[i]    <= '0;
        period_q[i] <= '0;
        cnt_q[i]    <= '0;
        pol_q[i]    <= '0;
      end
      pol_q[3]    <= POL_POS;
      for (int i = 0; i < 3; i++) ew_q[i] <= '0;
      nsr_q       <= '0;
      white_q     <= 1'b0;
      lat_ch_q    <= LATCH_NONE;
      lat_lo_q    <= '0;
      stereo_q    <= 8'hFF;
      frac_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cps_q       <= cps_d;
      over_q      <= over_d;
      mute_q      <= mute_d;
      vol_q       <= vol_d;
      period_q    <= period_d;
      cnt_q       <= cnt_d;
      pol_q       <= pol_d;
      ew_q        <= ew_d;
      nsr_q       <= nsr_d;
      white_q     <= white_d;
      lat_ch_q    <= lat_ch_d;
      lat_lo_q    <= lat_lo_d;
      stereo_q    <= stereo_d;
      frac_q      <= frac_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dec2_q  <= dec2_d;
    left_q  <= left_d;
    right_q <= right_d;
    prod_q  <= prod_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dneg_q  <= dneg_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### sv/square_tone_noise_sound_generator.sv
// Top level of the three-tone plus noise sound generator.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): each request carries a
// command and a byte: chip register write, stereo mask write, or sample tick.
// A write does not stall: the next request is taken in the cycle after it.
// A tick produces one stereo sample on the output channel (out_valid_o /
// out_stall_i / out_data_o): a multiply and accumulate step per channel on one
// shared multiplier, then decrement, evaluate and update steps per channel with
// a serial divide for each tone channel that flips while edge weighting is on,
// then a load of the output register. The sample sits in an output register;
// a stalled receiver holds it there and the next request is still taken; a
// later tick waits only to load it. Configuration (cfg_valid_i / cfg_ready_o,
// always ready) writes the clock ratio, the oversample flag and the channel
// mute mask; the user writes them only while idle, which the block does not
// enforce. Reset (rst_ni low, asynchronous) silences all channels, selects no
// latched channel, opens the stereo mask and empties the output register.
`timescale 1ns / 1ps
module square_tone_noise_sound_generator
  import stng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  stng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  stng_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .in_item_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_data_o)
  );

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == OP_LOAD_OUT) |-> (!out_valid_o || !out_stall_i))
    else $error("sample loaded over a pending one");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.cmd == CMD_TICK) |=> in_stall_o)
    else $error("tick request did not start the sequencer");

  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.cmd != CMD_TICK) |=> !in_stall_o)
    else $error("write request stalled the input");

endmodule

### tb/stng_checker.sv
// Checker for the sound generator: tracks chip state, predicts each sample and compares.
`timescale 1ns / 1ps
module stng_checker
  import stng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [19:0] clk_ratio;
  logic        os_on;
  logic [3:0]  ch_enable;

  logic [3:0]  atten [4];
  logic [9:0]  tone_per [4];
  int          cnt [4];
  int          pol [4];
  int          weight [3];
  logic [16:0] lfsr;
  logic        lfsr_white;
  logic [2:0]  latch_ch;
  logic [3:0]  latch_low;
  logic [7:0]  pan;
  logic [15:0] frac;

  out_item_t   samples_due [$];

  function automatic int level_of(input logic [3:0] att);
    case (att)
      4'd0, 4'd1, 4'd2: return 8028;
      4'd3:  return 6842;
      4'd4:  return 5603;
      4'd5:  return 4471;
      4'd6:  return 3636;
      4'd7:  return 2909;
      4'd8:  return 2316;
      4'd9:  return 1778;
      4'd10: return 1427;
      4'd11: return 1104;
      4'd12: return 862;
      4'd13: return 673;
      4'd14: return 539;
      default: return 0;
    endcase
  endfunction

  function automatic void clear_chip();
    clk_ratio = CLOCKS_RESET;
    os_on = 1'b0;
    ch_enable = MUTE_RESET;
    for (int i = 0; i < 4; i++) begin
      atten[i] = '0;
      tone_per[i] = '0;
      cnt[i] = 0;
      pol[i] = 0;
    end
    pol[3] = 1;
    for (int i = 0; i < 3; i++) weight[i] = 0;
    lfsr = '0;
    lfsr_white = 1'b0;
    latch_ch = LATCH_NONE;
    latch_low = '0;
    pan = 8'hFF;
    frac = '0;
  endfunction

  function automatic void reload(input int k);
    if (tone_per[k] > 0) begin
      while (cnt[k] < 0) cnt[k] += int'(tone_per[k]);
    end
  endfunction

  function automatic void chip_write(input logic [7:0] d);
    logic [9:0] p;
    if (!d[7]) begin
      if (latch_ch < LATCH_NONE) begin
        p = {d[5:0], latch_low};
        if (p < 10'd4) p = '0;
        tone_per[latch_ch[1:0]] = p;
        if (pol[latch_ch[1:0]] == 0) pol[latch_ch[1:0]] = 1;
      end
    end else if (!d[4]) begin
      if (d[6:5] == 2'b11) begin
        tone_per[3] = 10'h10 << d[1:0];
        lfsr_white = d[2];
        lfsr = '0;
        latch_ch = LATCH_NONE;
      end else begin
        latch_ch = {1'b0, d[6:5]};
        latch_low = d[3:0];
      end
    end else begin
      atten[d[6:5]] = d[3:0];
      latch_ch = LATCH_NONE;
    end
  endfunction

  function automatic out_item_t mix_and_advance();
    out_item_t r;
    int a [4];
    int left, right, n;
    logic [31:0] acc;
    left = 0;
    right = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = int'(ch_enable[i]) * level_of(atten[i]) * pol[i];
      if (os_on && weight[i] != 0) a[i] = a[i] * weight[i] / 256;
    end
    a[3] = int'(ch_enable[3]) * level_of(atten[3]) * int'(lfsr[0]);
    for (int i = 0; i < 4; i++) begin
      if (pan[i+4]) left += a[i];
      if (pan[i]) right += a[i];
    end
    r.left_sample = left[15:0];
    r.right_sample = right[15:0];

    acc = {16'd0, frac} + {12'd0, clk_ratio};
    n = int'(acc >> 16);
    frac = acc[15:0];

    for (int i = 0; i < 3; i++) if (tone_per[i] != 0) cnt[i] -= n;
    if (tone_per[3] == NOISE_FOLLOW) cnt[3] = cnt[2];
    else if (tone_per[3] != 0) cnt[3] -= n;

    for (int i = 0; i < 3; i++) begin
      if (cnt[i] < 0) begin
        if (os_on && n > 0) weight[i] = (n + 2 * cnt[i]) * 256 / n;
        pol[i] = -pol[i];
        reload(i);
      end else begin
        weight[i] = 0;
      end
    end

    if (cnt[3] < 0) begin
      pol[3] = -pol[3];
      reload(3);
      if (pol[3] == 1) begin
        if (lfsr == '0) lfsr = 17'd1;
        if (lfsr[0]) lfsr = (lfsr >> 1) ^ (lfsr_white ? WHITE_TAPS : PERIODIC_TAP);
        else lfsr = lfsr >> 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      clear_chip();
      samples_due.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (samples_due.size() == 0) begin
          $display("%0t: sample with none due: got %0d/%0d", $time,
                   out_data_i.left_sample, out_data_i.right_sample);
          fail_count_o++;
        end else begin
          want = samples_due.pop_front();
          if (want.left_sample !== out_data_i.left_sample) begin
            $display("%0t: left mismatch: expected %0d actual %0d", $time,
                     want.left_sample, out_data_i.left_sample);
            fail_count_o++;
          end
          if (want.right_sample !== out_data_i.right_sample) begin
            $display("%0t: right mismatch: expected %0d actual %0d", $time,
                     want.right_sample, out_data_i.right_sample);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CLOCKS_PER_SAMPLE: clk_ratio = cfg_data_i;
          CFG_OVERSAMPLE_ENABLE: os_on = cfg_data_i[0];
          CFG_MUTE_MASK:         ch_enable = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.cmd)
          CMD_CHIP_WRITE:   chip_write(in_data_i.data);
          CMD_STEREO_WRITE: pan = in_data_i.data;
          CMD_TICK:         samples_due.push_back(mix_and_advance());
          default: ;
        endcase
      end
      pending_o = samples_due.size();
    end
  end

endmodule

### tb/tb_top.sv
// Testbench top: clock, reset, request stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module tb_top;
  import stng_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 400;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_req;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_smp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;
  int          fail_count;
  int          pending;
  bit          calm;
  bit          long_hold;
  int          idle_cycles = 0;

  square_tone_noise_sound_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_smp),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  stng_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_smp),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      out_stall = !calm && ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(input logic [1:0] c, input logic [7:0] d);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_req.cmd = c;
    in_req.data = d;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_burst(input int count);
    int pick;
    logic [7:0] hi;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send(CMD_TICK, 8'($urandom));
      end else if (pick < 75) begin
        send(CMD_CHIP_WRITE, {1'b1, 2'($urandom_range(2)), 1'b0, 4'($urandom)});
        hi = 8'($urandom) & 8'h7F;
        if ($urandom_range(1)) hi[5:1] = '0;
        send(CMD_CHIP_WRITE, hi);
      end else if (pick < 85) begin
        send(CMD_CHIP_WRITE, {1'b1, 2'($urandom), 1'b1, 4'($urandom)});
      end else if (pick < 90) begin
        send(CMD_CHIP_WRITE, {3'b111, 1'b0, 4'($urandom)});
      end else if (pick < 95) begin
        send(CMD_STEREO_WRITE, 8'($urandom));
      end else if (pick < 98) begin
        send(CMD_CHIP_WRITE, 8'($urandom));
      end else begin
        send(CMD_UNUSED, 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CLOCKS_PER_SAMPLE;
    cfg_data = '0;
    calm = 1'b0;
    long_hold = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: volumes, tones, short period, lone data byte, noise forms, masks
    send(CMD_TICK, 8'h00);
    send(CMD_CHIP_WRITE, 8'h90);
    send(CMD_CHIP_WRITE, 8'hBF);
    send(CMD_CHIP_WRITE, 8'hD3);
    send(CMD_CHIP_WRITE, 8'hF0);
    send(CMD_CHIP_WRITE, 8'h8F);
    send(CMD_CHIP_WRITE, 8'h3F);
    send(CMD_CHIP_WRITE, 8'hA2);
    send(CMD_CHIP_WRITE, 8'h00);
    send(CMD_CHIP_WRITE, 8'hC5);
    send(CMD_CHIP_WRITE, 8'h00);
    send(CMD_CHIP_WRITE, 8'h7F);
    send(CMD_CHIP_WRITE, 8'hE7);
    send(CMD_TICK, 8'hFF);
    send(CMD_UNUSED, 8'hFF);
    send(CMD_STEREO_WRITE, 8'hA5);
    send(CMD_TICK, 8'h00);
    send(CMD_CHIP_WRITE, 8'hE0);
    send(CMD_STEREO_WRITE, 8'h00);
    send(CMD_TICK, 8'h00);
    send(CMD_CHIP_WRITE, 8'hE3);
    send(CMD_STEREO_WRITE, 8'hFF);
    send(CMD_TICK, 8'h00);
    send(CMD_CHIP_WRITE, 8'hE6);
    send(CMD_TICK, 8'h00);
    random_burst(205);
    drain();

    cfg_write(CFG_CLOCKS_PER_SAMPLE, 20'hFFFFF);
    cfg_write(CFG_OVERSAMPLE_ENABLE, 20'd1);
    cfg_write(CFG_MUTE_MASK, 20'hF);
    long_hold = 1'b1;
    random_burst(210);
    drain();

    cfg_write(CFG_CLOCKS_PER_SAMPLE, 20'd0);
    calm = 1'b1;
    random_burst(210);
    calm = 1'b0;
    drain();

    cfg_write(CFG_CLOCKS_PER_SAMPLE, 20'd196731);
    cfg_write(CFG_MUTE_MASK, 20'hA);
    random_burst(210);
    drain();

    cfg_write(CFG_CLOCKS_PER_SAMPLE, 20'($urandom));
    cfg_write(CFG_OVERSAMPLE_ENABLE, 20'd0);
    cfg_write(CFG_MUTE_MASK, 20'h0);
    random_burst(210);
    drain();

    cfg_write(CFG_CLOCKS_PER_SAMPLE, 20'($urandom_range(20'hFFFFF, 20'h40000)));
    cfg_write(CFG_OVERSAMPLE_ENABLE, 20'd1);
    cfg_write(CFG_MUTE_MASK, 20'($urandom_range(15, 1)));
    random_burst(210);
    drain();

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
sv/stng_pkg.sv
sv/stng_ctrl.sv
sv/stng_dp.sv
sv/square_tone_noise_sound_generator.sv
tb/stng_checker.sv
tb/tb_top.sv
